// ----- src/isup_pkg.sv -----
// Shared types and constants of the ink stroke unit parser.
package isup_pkg;

    // Parser phases, one-hot.
    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_COUNT  = 11'b000_0000_0010,
        PH_HEADER = 11'b000_0000_0100,
        PH_SX     = 11'b000_0000_1000,
        PH_SMID   = 11'b000_0001_0000,
        PH_SY     = 11'b000_0010_0000,
        PH_FA     = 11'b000_0100_0000,
        PH_FB     = 11'b000_1000_0000,
        PH_NA     = 11'b001_0000_0000,
        PH_NB     = 11'b010_0000_0000,
        PH_DONE   = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_POINT = 3'd0,
        KIND_CHAR  = 3'd1,
        KIND_IMAGE = 3'd2,
        KIND_SPACE = 3'd3,
        KIND_ENTER = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] x;
        logic [7:0] y;
        logic       stroke_last;
    } t_evt;

    localparam logic [7:0] MARK_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;
    localparam logic [3:0] NIB_SPACE   = 4'h9;
    localparam logic [3:0] NIB_ENTER   = 4'hB;
    localparam logic [1:0] COUNT_LAST  = 2'd3;

    // A byte above 128 stands for the negative delta 128 minus the byte.
    function automatic logic [7:0] delta_of(input logic [7:0] b);
        logic [7:0] d;
        d = (b > MARK_BYTE) ? (MARK_BYTE - b) : b;
        return d;
    endfunction

endpackage

// ----- src/isup_if.sv -----
// Handshake channel interfaces for document words and parse events.
interface isup_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface isup_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic       stroke_last;

    modport source (output valid, output kind, output x, output y, output stroke_last,
                    input ready);
    modport sink   (input valid, input kind, input x, input y, input stroke_last,
                    output ready);
endinterface

// ----- src/isup_core.sv -----
// Parser state and the per-word next-state and event logic.
module isup_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_frame_start,
    output logic              o_res_vld,
    output isup_pkg::t_evt    o_res
);

    isup_pkg::t_phase r_phase, n_phase, ph_eff;
    logic [1:0]  r_pos, n_pos, pos_eff;
    logic [31:0] r_units, n_units, units_eff, units_dec;
    logic [7:0]  r_held_a, n_held_a;
    logic [7:0]  r_held_b, n_held_b;
    logic [7:0]  r_last_x, n_last_x;
    logic [7:0]  r_last_y, n_last_y;
    logic [7:0]  r_dx, n_dx;
    logic [7:0]  r_dy, n_dy;
    logic [7:0]  sum_x, sum_y;
    logic        unit_done;

    // A frame start drops all progress and the word is the first count byte.
    assign ph_eff    = i_frame_start ? isup_pkg::PH_COUNT : r_phase;
    assign pos_eff   = i_frame_start ? 2'd0 : r_pos;
    assign units_eff = i_frame_start ? 32'd0 : r_units;
    assign units_dec = r_units - 32'd1;
    assign unit_done = (r_units == 32'd1);
    assign sum_x     = r_last_x + r_dx;
    assign sum_y     = r_last_y + r_dy;

    always_comb begin
        n_phase   = ph_eff;
        n_pos     = pos_eff;
        n_units   = units_eff;
        n_held_a  = r_held_a;
        n_held_b  = r_held_b;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        n_dx      = r_dx;
        n_dy      = r_dy;
        o_res_vld = 1'b0;
        o_res     = '{kind: isup_pkg::KIND_POINT, x: 8'd0, y: 8'd0, stroke_last: 1'b0};

        case (ph_eff)
            isup_pkg::PH_COUNT: begin
                n_units = {units_eff[23:0], i_byte};
                if (pos_eff == isup_pkg::COUNT_LAST) begin
                    n_pos = 2'd0;
                    if (n_units == 32'd0 || n_units[31]) begin
                        n_phase = isup_pkg::PH_DONE;
                    end else begin
                        n_phase = isup_pkg::PH_HEADER;
                    end
                end else begin
                    n_pos = pos_eff + 2'd1;
                end
            end
            isup_pkg::PH_HEADER: begin
                if (!i_byte[7] && !i_byte[6]) begin
                    n_phase = isup_pkg::PH_SX;
                end else begin
                    n_units = units_dec;
                    n_phase = unit_done ? isup_pkg::PH_DONE : isup_pkg::PH_HEADER;
                    if (!i_byte[7]) begin
                        if (i_byte[3]) begin
                            o_res_vld  = 1'b1;
                            o_res.kind = isup_pkg::KIND_IMAGE;
                        end
                    end else if (i_byte[7:4] == isup_pkg::NIB_SPACE) begin
                        o_res_vld  = 1'b1;
                        o_res.kind = isup_pkg::KIND_SPACE;
                    end else if (i_byte[7:4] == isup_pkg::NIB_ENTER) begin
                        o_res_vld  = 1'b1;
                        o_res.kind = isup_pkg::KIND_ENTER;
                    end
                end
            end
            isup_pkg::PH_SX: begin
                n_held_a = i_byte;
                n_phase  = isup_pkg::PH_SMID;
            end
            isup_pkg::PH_SMID: begin
                // The pair 0x80,0x80 in place of a start point ends the character.
                if (r_held_a == isup_pkg::MARK_BYTE && i_byte == isup_pkg::MARK_BYTE) begin
                    n_units    = units_dec;
                    n_phase    = unit_done ? isup_pkg::PH_DONE : isup_pkg::PH_HEADER;
                    o_res_vld  = 1'b1;
                    o_res.kind = isup_pkg::KIND_CHAR;
                end else begin
                    n_held_b = i_byte;
                    n_phase  = isup_pkg::PH_SY;
                end
            end
            isup_pkg::PH_SY: begin
                n_last_x   = {r_held_a[3:0], r_held_b[7:4]};
                n_last_y   = i_byte;
                n_phase    = isup_pkg::PH_FA;
                o_res_vld  = 1'b1;
                o_res.x    = {r_held_a[3:0], r_held_b[7:4]};
                o_res.y    = i_byte;
            end
            isup_pkg::PH_FA, isup_pkg::PH_NA: begin
                n_held_a = i_byte;
                n_phase  = (ph_eff == isup_pkg::PH_FA) ? isup_pkg::PH_FB : isup_pkg::PH_NB;
            end
            isup_pkg::PH_FB: begin
                if (r_held_a == isup_pkg::MARK_BYTE && i_byte == isup_pkg::ZERO_BYTE) begin
                    n_phase = isup_pkg::PH_SX;
                end else begin
                    n_dx    = isup_pkg::delta_of(r_held_a);
                    n_dy    = isup_pkg::delta_of(i_byte);
                    n_phase = isup_pkg::PH_NA;
                end
            end
            isup_pkg::PH_NB: begin
                // The point waits until the pair after it tells whether it ends the stroke.
                n_last_x  = sum_x;
                n_last_y  = sum_y;
                o_res_vld = 1'b1;
                o_res.x   = sum_x;
                o_res.y   = sum_y;
                if (r_held_a == isup_pkg::MARK_BYTE && i_byte == isup_pkg::ZERO_BYTE) begin
                    n_phase           = isup_pkg::PH_SX;
                    o_res.stroke_last = 1'b1;
                end else begin
                    n_dx    = isup_pkg::delta_of(r_held_a);
                    n_dy    = isup_pkg::delta_of(i_byte);
                    n_phase = isup_pkg::PH_NA;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= isup_pkg::PH_IDLE;
            r_pos    <= 2'd0;
            r_units  <= 32'd0;
            r_held_a <= 8'd0;
            r_held_b <= 8'd0;
            r_last_x <= 8'd0;
            r_last_y <= 8'd0;
            r_dx     <= 8'd0;
            r_dy     <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_units  <= n_units;
            r_held_a <= n_held_a;
            r_held_b <= n_held_b;
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
        end
    end

endmodule

// ----- src/ink_stroke_unit_parser.sv -----
// Top level of the ink stroke unit parser: input register, parser core, result register.
//
// i_byte carries one decoded document word per handshake: data_byte and
// frame_start, which restarts the parser on the first count byte of a document.
// o_evt carries at most one event per input word: a stroke point (with x, y and
// stroke_last), a character-done marker, or an image, space or enter marker.
// Words that produce no event are consumed silently.
// A word is held in the input register, and its event is then registered in the
// result register. Throughput: one word per cycle while the receiver does not stall;
// the parser state update is a single pass of short logic with two 8-bit adds and a
// 32-bit decrement, between the input register and the result register.
// Reset (synchronous, active low) empties both registers and puts the parser in
// the idle phase, where words are ignored until a frame start arrives.
// When the receiver stalls, the pending event holds in the result register and
// one more word is held in the input register; after that i_byte.ready drops
// until the event is taken.
module ink_stroke_unit_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    isup_byte_if.sink  i_byte,
    isup_evt_if.source o_evt
);

    logic           r_in_vld;
    logic [7:0]     r_in_byte;
    logic           r_in_fs;
    logic           r_out_vld;
    isup_pkg::t_evt r_out;
    logic           advance;
    logic           res_vld;
    isup_pkg::t_evt res;

    assign advance      = r_in_vld && (!r_out_vld || o_evt.ready);
    assign i_byte.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_fs   <= i_byte.frame_start;
        end
    end

    isup_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_byte        (r_in_byte),
        .i_frame_start (r_in_fs),
        .o_res_vld     (res_vld),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= res_vld;
        end else if (o_evt.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_vld) begin
            r_out <= res;
        end
    end

    assign o_evt.valid       = r_out_vld;
    assign o_evt.kind        = r_out.kind;
    assign o_evt.x           = r_out.x;
    assign o_evt.y           = r_out.y;
    assign o_evt.stroke_last = r_out.stroke_last;

endmodule
